@@ hdl/radix_digit_word_converter_top_macros.svh @@
// assertion macros for the radix digit word converter
// used by radix_digit_word_converter_top; no other dependencies
`ifndef RADIX_DIGIT_WORD_CONVERTER_TOP_MACROS_SVH
`define RADIX_DIGIT_WORD_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTH
// checked out of reset only
`define RDWC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// checked on every edge, reset included
`define RDWC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define RDWC_ASSERT(label, clk, rst_n, prop)
`define RDWC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ hdl/rdwc_pkg.sv @@
// shared types and constants of the radix digit word converter
// no dependencies
package rdwc_pkg;

    localparam int VAL_W    = 30;
    localparam int CONV_W   = 60;
    localparam int SB_W     = 4;
    localparam int TB_W     = 5;
    localparam int REM_W    = 4;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int MAX_DIGS = 18;

    localparam int DEC_RADIX  = 10;
    localparam int HEX_RADIX  = 16;
    localparam int NIBBLE_CAP = 15;

    localparam logic [0:0] REG_SOURCE_BASE = 1'b0;
    localparam logic [0:0] REG_TARGET_BASE = 1'b1;

    localparam logic [SB_W-1:0] SB_RESET = 4'd2;
    localparam logic [TB_W-1:0] TB_RESET = 5'd8;

    // clamped configuration seen by the datapath
    typedef struct packed {
        logic [SB_W-1:0] source_base;
        logic [TB_W-1:0] target_base;
        logic            hex_pack;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [TB_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quot;
        logic [REM_W-1:0] rem;
    } t_div_rsp;

    // number with count digits of value one in the given radix
    function automatic logic [CONV_W-1:0] repunit(input int count, input int radix);
        logic [CONV_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < MAX_DIGS; k++) begin
            if (k < count) begin
                acc = CONV_W'(acc * CONV_W'(radix)) + CONV_W'(1);
            end
        end
        return acc;
    endfunction

endpackage

@@ hdl/rdwc_cfg_regs.sv @@
// apb configuration registers: source and target base, with range clamping
// depends on rdwc_pkg
module rdwc_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rdwc_pkg::ADDR_W-1:0] paddr,
    input  logic [rdwc_pkg::DATA_W-1:0] pwdata,
    output logic [rdwc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output rdwc_pkg::t_cfg             o_cfg
);

    logic [rdwc_pkg::SB_W-1:0] r_source_base;
    logic [rdwc_pkg::TB_W-1:0] r_target_base;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_base <= rdwc_pkg::SB_RESET;
            r_target_base <= rdwc_pkg::TB_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                rdwc_pkg::REG_SOURCE_BASE: r_source_base <= pwdata[rdwc_pkg::SB_W-1:0];
                rdwc_pkg::REG_TARGET_BASE: r_target_base <= pwdata[rdwc_pkg::TB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rdwc_pkg::REG_SOURCE_BASE:
                prdata = rdwc_pkg::DATA_W'(r_source_base);
            rdwc_pkg::REG_TARGET_BASE:
                prdata = rdwc_pkg::DATA_W'(r_target_base);
            default:
                prdata = '0;
        endcase
    end

    // out-of-range bases clamp to the nearest legal one
    always_comb begin
        if (r_source_base < 4'd2) begin
            o_cfg.source_base = 4'd2;
        end else if (r_source_base > 4'(rdwc_pkg::DEC_RADIX)) begin
            o_cfg.source_base = 4'(rdwc_pkg::DEC_RADIX);
        end else begin
            o_cfg.source_base = r_source_base;
        end
        if (r_target_base < 5'd2) begin
            o_cfg.target_base = 5'd2;
        end else if (r_target_base > 5'(rdwc_pkg::HEX_RADIX)) begin
            o_cfg.target_base = 5'(rdwc_pkg::HEX_RADIX);
        end else begin
            o_cfg.target_base = r_target_base;
        end
        o_cfg.hex_pack = (o_cfg.target_base > 5'(rdwc_pkg::DEC_RADIX));
    end

endmodule

@@ hdl/rdwc_divider.sv @@
// shared divider by a small divisor (2..16): reciprocal multiply plus one correction
// depends on rdwc_pkg; the product high bits are registered, then the corrected quotient and remainder
module rdwc_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rdwc_pkg::t_div_req i_req,
    output rdwc_pkg::t_div_rsp o_rsp
);

    localparam int VW = rdwc_pkg::VAL_W;

    // floor(2^32 / d)
    function automatic logic [31:0] recip(input logic [rdwc_pkg::TB_W-1:0] d);
        case (d)
            5'd2:    return 32'h8000_0000;
            5'd3:    return 32'h5555_5555;
            5'd4:    return 32'h4000_0000;
            5'd5:    return 32'h3333_3333;
            5'd6:    return 32'h2AAA_AAAA;
            5'd7:    return 32'h2492_4924;
            5'd8:    return 32'h2000_0000;
            5'd9:    return 32'h1C71_C71C;
            5'd10:   return 32'h1999_9999;
            5'd11:   return 32'h1745_D174;
            5'd12:   return 32'h1555_5555;
            5'd13:   return 32'h13B1_3B13;
            5'd14:   return 32'h1249_2492;
            5'd15:   return 32'h1111_1111;
            5'd16:   return 32'h1000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    logic [VW+31:0]             prod;
    logic [VW-1:0]              r_hi;
    logic [VW-1:0]              r_v;
    logic [rdwc_pkg::TB_W-1:0]  r_d;
    logic                       r_a_vld;
    logic [VW+4:0]              qd;
    logic [VW+4:0]              diff;
    logic [5:0]                 r0;
    logic [5:0]                 r1;
    logic                       fix;
    logic [VW-1:0]              r_q;
    logic [rdwc_pkg::REM_W-1:0] r_r;
    logic                       r_done;

    assign prod = (VW+32)'(i_req.dividend) * (VW+32)'(recip(i_req.divisor));

    // estimate is the true quotient or one below it
    assign qd   = (VW+5)'(r_hi) * (VW+5)'(r_d);
    assign diff = (VW+5)'(r_v) - qd;
    assign r0   = diff[5:0];
    assign fix  = (r0 >= 6'(r_d));
    assign r1   = fix ? (r0 - 6'(r_d)) : r0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_a_vld <= i_req.start;
            r_done  <= r_a_vld;
        end
        r_hi <= prod[VW+31:32];
        r_v  <= i_req.dividend;
        r_d  <= i_req.divisor;
        r_q  <= r_hi + VW'(fix);
        r_r  <= r1[rdwc_pkg::REM_W-1:0];
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

endmodule

@@ hdl/radix_digit_word_converter_top.sv @@
// top level of the radix digit word converter: stream ports, apb config, sequencer
// depends on rdwc_pkg, rdwc_cfg_regs, rdwc_divider and the macros header
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata: digit_word
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: binary_value, converted_word
//            |     |                              | tuser: digit_error, overflow
//  apb       | in  | psel/penable/pwrite, pready  | 0x0 source_base, 0x4 target_base
//
//  one beat reads the source digits, one division per digit (stops early once the remaining
//  digits are zero), then a setup step, then the target digits, one division per digit
//  (stops at the output capacity), then loads the output register once it is free and
//  goes idle to take the next beat; the pace is set by the turnaround of the one shared
//  divider
//  s_axis_tready is high only while the sequencer is idle; a result waiting on m_axis does
//  not block the next beat, only the write of the next result
//  synchronous active-low reset; no clearing pass
`include "radix_digit_word_converter_top_macros.svh"

module radix_digit_word_converter_top #(
    parameter int IN_DIGITS  = 9,
    parameter int OUT_DIGITS = 18
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // s_axis: tdata [29:0] digit_word, [31:30] zero
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,
    // m_axis: tdata [29:0] binary_value, [89:30] converted_word, [95:90] zero
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [95:0]                 m_axis_tdata,
    // m_axis: tuser [0] digit_error, [1] overflow
    output logic [1:0]                  m_axis_tuser,
    // apb configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rdwc_pkg::ADDR_W-1:0] paddr,
    input  logic [rdwc_pkg::DATA_W-1:0] pwdata,
    output logic [rdwc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int VW      = rdwc_pkg::VAL_W;
    localparam int CW      = rdwc_pkg::CONV_W;
    localparam int DIG_W   = $clog2(IN_DIGITS + 1);
    localparam int CNT_W   = $clog2(OUT_DIGITS + 1);
    localparam int CAP_DEC = OUT_DIGITS;
    localparam int CAP_HEX = (OUT_DIGITS < rdwc_pkg::NIBBLE_CAP) ? OUT_DIGITS
                                                                 : rdwc_pkg::NIBBLE_CAP;
    // all-ones-digit patterns, scaled by (base - 1) for saturation
    localparam logic [CW-1:0] DEC_REP = rdwc_pkg::repunit(CAP_DEC, rdwc_pkg::DEC_RADIX);
    localparam logic [CW-1:0] HEX_REP = rdwc_pkg::repunit(CAP_HEX, rdwc_pkg::HEX_RADIX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_CONV_START,
        S_CONV,
        S_FLUSH
    } t_state;

    rdwc_pkg::t_cfg     cfg;
    rdwc_pkg::t_div_req div_req;
    rdwc_pkg::t_div_rsp div_rsp;

    t_state            r_state,     n_state;
    logic [VW-1:0]     r_value,     n_value;
    logic [VW-1:0]     r_weight,    n_weight;
    logic              r_bad,       n_bad;
    logic [DIG_W-1:0]  r_dig_cnt,   n_dig_cnt;
    logic [CW-1:0]     r_conv,      n_conv;
    logic [CW-1:0]     r_place,     n_place;
    logic [CNT_W-1:0]  r_out_cnt,   n_out_cnt;
    logic              r_ovf,       n_ovf;
    logic              r_out_valid, n_out_valid;
    logic [95:0]       r_out_tdata, n_out_tdata;
    logic [1:0]        r_out_tuser, n_out_tuser;

    logic [DIG_W-1:0]  dig_cnt_inc;
    logic [CNT_W-1:0]  out_cnt_inc;
    logic [CNT_W-1:0]  cap_sel;
    logic [3:0]        tb_m1;
    logic [CW-1:0]     sat_word;
    logic [CW-1:0]     conv_sel;

    rdwc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rdwc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    assign dig_cnt_inc = r_dig_cnt + DIG_W'(1);
    assign out_cnt_inc = r_out_cnt + CNT_W'(1);
    // nibble packing holds at most fifteen digits in the 60-bit word
    assign cap_sel     = cfg.hex_pack ? CNT_W'(CAP_HEX) : CNT_W'(CAP_DEC);
    assign tb_m1       = 4'(cfg.target_base - 5'd1);
    assign sat_word    = (cfg.hex_pack ? HEX_REP : DEC_REP) * CW'(tb_m1);
    assign conv_sel    = r_ovf ? sat_word : r_conv;

    always_comb begin
        n_state      = r_state;
        n_value      = r_value;
        n_weight     = r_weight;
        n_bad        = r_bad;
        n_dig_cnt    = r_dig_cnt;
        n_conv       = r_conv;
        n_place      = r_place;
        n_out_cnt    = r_out_cnt;
        n_ovf        = r_ovf;
        n_out_tdata  = r_out_tdata;
        n_out_tuser  = r_out_tuser;
        n_out_valid  = r_out_valid & ~m_axis_tready;

        div_req.start    = 1'b0;
        div_req.dividend = div_rsp.quot;
        div_req.divisor  = 5'(rdwc_pkg::DEC_RADIX);

        case (r_state)
            S_IDLE: begin
                // first decimal digit split starts on the accepting edge
                if (s_axis_tvalid) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = s_axis_tdata[VW-1:0];
                    n_value          = '0;
                    n_weight         = VW'(1);
                    n_bad            = 1'b0;
                    n_dig_cnt        = '0;
                    n_state          = S_DEC;
                end
            end
            S_DEC: begin
                // remainder is one source digit, least significant first
                if (div_rsp.done) begin
                    n_value   = r_value + VW'(r_weight * VW'(div_rsp.rem));
                    n_weight  = VW'(r_weight * VW'(cfg.source_base));
                    n_bad     = r_bad | (div_rsp.rem >= cfg.source_base);
                    n_dig_cnt = dig_cnt_inc;
                    if ((div_rsp.quot == '0) || (dig_cnt_inc == DIG_W'(IN_DIGITS))) begin
                        n_state = S_CONV_START;
                    end else begin
                        div_req.start = 1'b1;
                    end
                end
            end
            S_CONV_START: begin
                n_conv    = '0;
                n_place   = CW'(1);
                n_out_cnt = '0;
                n_ovf     = 1'b0;
                if (r_value == '0) begin
                    n_state = S_FLUSH;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_value;
                    div_req.divisor  = cfg.target_base;
                    n_state          = S_CONV;
                end
            end
            S_CONV: begin
                div_req.divisor = cfg.target_base;
                if (div_rsp.done) begin
                    n_conv    = r_conv + CW'(r_place * CW'(div_rsp.rem));
                    n_place   = cfg.hex_pack ? (r_place << 4)
                                             : ((r_place << 3) + (r_place << 1));
                    n_out_cnt = out_cnt_inc;
                    if (div_rsp.quot == '0) begin
                        n_state = S_FLUSH;
                    end else if (out_cnt_inc == cap_sel) begin
                        // more digits remain beyond capacity
                        n_ovf   = 1'b1;
                        n_state = S_FLUSH;
                    end else begin
                        div_req.start = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                // wait only for the output register to free up
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_tdata = {6'd0, conv_sel, r_value};
                    n_out_tuser = {r_ovf, r_bad};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_value     <= n_value;
        r_weight    <= n_weight;
        r_bad       <= n_bad;
        r_dig_cnt   <= n_dig_cnt;
        r_conv      <= n_conv;
        r_place     <= n_place;
        r_out_cnt   <= n_out_cnt;
        r_ovf       <= n_ovf;
        r_out_tdata <= n_out_tdata;
        r_out_tuser <= n_out_tuser;
    end

    // divider results only land while the sequencer waits for them
    `RDWC_ASSERT(a_done_in_wait, i_clk, i_rst_n, div_rsp.done |-> ((r_state == S_DEC) || (r_state == S_CONV)))
    // an accepted beat always launches the first digit split
    `RDWC_ASSERT(a_accept_starts, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |-> div_req.start)
    // no new division while one is still in flight
    `RDWC_ASSERT(a_no_back_to_back_start, i_clk, i_rst_n, div_req.start |=> !div_req.start)
    // reset drops any pending result
    `RDWC_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

@@ dv/rdwc_checker.sv @@
`timescale 1ns / 1ps
// result checker for the radix digit word converter: follows the apb writes, checks the readback,
// predicts every result beat and compares it with what leaves m_axis; depends on rdwc_pkg
module rdwc_checker #(
    parameter int IN_DIGITS  = 9,
    parameter int OUT_DIGITS = 18
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [31:0]                 i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [95:0]                 i_out_data,
    input  logic [1:0]                  i_out_user,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [rdwc_pkg::ADDR_W-1:0] i_paddr,
    input  logic [rdwc_pkg::DATA_W-1:0] i_pwdata,
    input  logic [rdwc_pkg::DATA_W-1:0] i_prdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_pending
);
    import rdwc_pkg::*;

    localparam int MIN_RADIX = 2;

    typedef struct packed {
        logic [VAL_W-1:0]  binary_value;
        logic [CONV_W-1:0] converted_word;
        logic              digit_error;
        logic              overflow;
    } conversion_t;

    conversion_t       conversions_due[$];
    logic [SB_W-1:0]   source_base_copy;
    logic [TB_W-1:0]   target_base_copy;
    int                fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = conversions_due.size();

    // value of the source-base digits, then that value rewritten in the target base
    function automatic conversion_t convert_word(input logic [VAL_W-1:0] word,
                                                 input logic [SB_W-1:0] sb_reg,
                                                 input logic [TB_W-1:0] tb_reg);
        longint unsigned rest, value, weight, sb, tb, pack, cap, conv, place, v, digit, count;
        int              k;
        logic            bad;
        conversion_t     r;
        sb = (sb_reg < MIN_RADIX) ? MIN_RADIX : (sb_reg > DEC_RADIX) ? DEC_RADIX : sb_reg;
        tb = (tb_reg < MIN_RADIX) ? MIN_RADIX : (tb_reg > HEX_RADIX) ? HEX_RADIX : tb_reg;
        rest   = word;
        value  = 0;
        weight = 1;
        bad    = 1'b0;
        // higher decimal digits than IN_DIGITS are dropped
        for (k = 0; k < IN_DIGITS; k++) begin
            digit = rest % DEC_RADIX;
            rest  = rest / DEC_RADIX;
            if (digit >= sb) begin
                bad = 1'b1;
            end
            value  = value + digit * weight;
            weight = weight * sb;
        end
        // bases above ten go out as nibbles, capped at what 60 bits hold
        pack = (tb <= DEC_RADIX) ? DEC_RADIX : HEX_RADIX;
        cap  = OUT_DIGITS;
        if (pack == HEX_RADIX && cap > NIBBLE_CAP) begin
            cap = NIBBLE_CAP;
        end
        conv  = 0;
        place = 1;
        count = 0;
        v     = value;
        while (v != 0) begin
            digit = v % tb;
            v     = v / tb;
            if (count < cap) begin
                conv  = conv + digit * place;
                place = place * pack;
            end
            count++;
        end
        // saturate to the top digit in every position
        if (count > cap) begin
            conv = 0;
            for (k = 0; k < cap; k++) begin
                conv = conv * pack + (tb - 1);
            end
        end
        r.binary_value   = value[VAL_W-1:0];
        r.converted_word = conv[CONV_W-1:0];
        r.digit_error    = bad;
        r.overflow       = (count > cap);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        conversion_t       got, want;
        logic [DATA_W-1:0] reg_value;
        if (!i_rst_n) begin
            conversions_due.delete();
            source_base_copy = SB_RESET;
            target_base_copy = TB_RESET;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.binary_value   = i_out_data[VAL_W-1:0];
                got.converted_word = i_out_data[VAL_W+CONV_W-1:VAL_W];
                got.digit_error    = i_out_user[0];
                got.overflow       = i_out_user[1];
                if (conversions_due.size() == 0) begin
                    flag_mismatch("unrequested result", '0, 64'(got.binary_value));
                end else begin
                    want = conversions_due.pop_front();
                    if (got.binary_value !== want.binary_value)
                        flag_mismatch("binary_value", 64'(want.binary_value),
                                      64'(got.binary_value));
                    if (got.converted_word !== want.converted_word)
                        flag_mismatch("converted_word", 64'(want.converted_word),
                                      64'(got.converted_word));
                    if (got.digit_error !== want.digit_error)
                        flag_mismatch("digit_error", 64'(want.digit_error),
                                      64'(got.digit_error));
                    if (got.overflow !== want.overflow)
                        flag_mismatch("overflow", 64'(want.overflow), 64'(got.overflow));
                end
            end
            if (i_in_valid && i_in_ready) begin
                conversions_due = {conversions_due,
                                   convert_word(i_in_data[VAL_W-1:0],
                                                source_base_copy, target_base_copy)};
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == {REG_SOURCE_BASE, 2'b00}) begin
                        source_base_copy = i_pwdata[SB_W-1:0];
                    end else if (i_paddr == {REG_TARGET_BASE, 2'b00}) begin
                        target_base_copy = i_pwdata[TB_W-1:0];
                    end
                end else begin
                    reg_value = (i_paddr == {REG_SOURCE_BASE, 2'b00}) ?
                                DATA_W'(source_base_copy) : DATA_W'(target_base_copy);
                    if (i_prdata !== reg_value) begin
                        flag_mismatch("register readback", 64'(reg_value), 64'(i_prdata));
                    end
                end
            end
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// testbench top for radix_digit_word_converter_top: clock, reset, stream and apb stimulus
// and the verdict; depends on rdwc_pkg and rdwc_checker
module tb;
    import rdwc_pkg::*;

    localparam int IN_DIGITS       = 9;
    localparam int OUT_DIGITS      = 18;
    localparam int PHASES          = 20;
    localparam int BEATS_PER_PHASE = 25;
    localparam int STALL_CYCLES    = 400;
    // longest time from one accepted beat to the next when the result side does not hold off
    localparam int BEAT_LATENCY    = 2 * IN_DIGITS + 2 * OUT_DIGITS + 3;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata  = '0;   // [29:0] digit_word, [31:30] zero
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [95:0]       m_axis_tdata;         // [29:0] binary_value, [89:30] converted_word
    logic [1:0]        m_axis_tuser;         // [0] digit_error, [1] overflow
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;

    // idle odds in percent per cycle, changed between phases
    int send_idle = 13;
    int recv_idle = 54;

    // receiver hold-off request and its private countdown
    int stall_len  = 0;
    int stall_id   = 0;
    int stall_seen = 0;
    int stall_left = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    radix_digit_word_converter_top #(
        .IN_DIGITS (IN_DIGITS),
        .OUT_DIGITS(OUT_DIGITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    rdwc_checker #(
        .IN_DIGITS (IN_DIGITS),
        .OUT_DIGITS(OUT_DIGITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // result side: random back-pressure, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (stall_id != stall_seen) begin
            stall_seen = stall_id;
            stall_left = stall_len;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // one input beat; valid stays up when the next beat follows without a gap
    task automatic send_beat(input logic [VAL_W-1:0] word);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, word};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    // stop sending and wait until every predicted result has come out
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [0:0] idx,
                              input logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // reprogram both bases on an idle block and read them back
    task automatic set_bases(input logic [DATA_W-1:0] sb_word, input logic [DATA_W-1:0] tb_word);
        wait_for_results();
        apb_access(1'b1, REG_SOURCE_BASE, sb_word);
        apb_access(1'b1, REG_TARGET_BASE, tb_word);
        apb_access(1'b0, REG_SOURCE_BASE, '0);
        apb_access(1'b0, REG_TARGET_BASE, '0);
    endtask

    initial begin
        logic [DATA_W-1:0] sb_word, tb_word;
        logic [VAL_W-1:0]  word;
        int unsigned       acc;
        int                sb_eff, kind, len, bad_pos, digit, phase, n, j;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset bases: binary in, octal out; all-ones word has bad digits and a tenth digit
        send_beat(30'd0);
        send_beat(30'd111111111);
        send_beat(30'h3FFF_FFFF);
        // binary out: 18 digits exactly fit, one more overflows
        set_bases(10, 2);
        send_beat(30'd262143);
        send_beat(30'd262144);
        send_beat(30'd999999999);
        // hex nibbles
        set_bases(10, 16);
        send_beat(30'd999999999);
        send_beat(30'd0);
        send_beat(30'd1);
        set_bases(10, 10);
        send_beat(30'd999999999);
        send_beat(30'd123456789);
        set_bases(2, 2);
        send_beat(30'd123);
        send_beat(30'd1);
        // bases below range clamp to 2
        set_bases(0, 1);
        send_beat(30'd101);
        send_beat(30'd1111);
        // bases above range clamp to 10 and 16; digit above the ninth ignored
        set_bases(15, 31);
        send_beat(30'd987654321);
        send_beat(30'd1000000000);
        // base 11 still packs as nibbles; 9 is a bad digit in base 9
        set_bases(9, 11);
        send_beat(30'd888888888);
        send_beat(30'd9);
        // ternary out around the 18-digit edge
        set_bases(10, 3);
        send_beat(30'd387420488);
        send_beat(30'd387420489);
        set_bases(7, 15);
        send_beat(30'd666666666);
        set_bases(3, 17);
        send_beat(30'd222);

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == 7) begin
                send_idle = 54;
                recv_idle = 13;
            end else if (phase == 14) begin
                send_idle = 0;
                recv_idle = 0;
            end
            // mostly legal bases, now and then out of range; junk in the unused bits
            sb_word = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 10) : $urandom_range(0, 15);
            tb_word = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 16) : $urandom_range(0, 31);
            sb_eff  = (sb_word[3:0] < 2) ? 2 : (sb_word[3:0] > 10) ? 10 : sb_word[3:0];
            sb_word = ($urandom() & ~32'hF) | sb_word;
            tb_word = ($urandom() & ~32'h1F) | tb_word;
            set_bases(sb_word, tb_word);

            // long hold-off on the result side while beats keep coming
            if (phase == 3 || phase == 16) begin
                stall_len <= STALL_CYCLES;
                stall_id  <= stall_id + 1;
            end

            for (n = 0; n < BEATS_PER_PHASE; n++) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    word = VAL_W'($urandom());
                end else if (kind == 1) begin
                    word = VAL_W'($urandom_range(1000000000, 32'h3FFF_FFFF));
                end else begin
                    // legal digits, all-top digits, or one bad digit at a random place
                    len     = (kind == 2) ? IN_DIGITS : $urandom_range(1, IN_DIGITS);
                    bad_pos = (kind == 3) ? $urandom_range(0, len - 1) : -1;
                    acc     = 0;
                    for (j = len - 1; j >= 0; j--) begin
                        if (j == bad_pos && sb_eff < 10)
                            digit = $urandom_range(sb_eff, 9);
                        else if (kind == 2)
                            digit = sb_eff - 1;
                        else
                            digit = $urandom_range(0, sb_eff - 1);
                        acc = acc * 10 + digit;
                    end
                    word = acc[VAL_W-1:0];
                end
                send_beat(word);
            end
        end

        wait_for_results();
        repeat (2 * BEAT_LATENCY) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
